/* design/mckb_pkg.sv */
// ----------------------------------------------------------------------------
// mckb_pkg
// Shared types and constants for the mirrored color-key blitter.
// ----------------------------------------------------------------------------
package mckb_pkg;

    localparam int SURF_W_BITS   = 12;
    localparam int SPRITE_W_BITS = 11;
    localparam int COUNT_BITS    = 10;
    localparam int COORD_BITS    = 13;
    localparam int PIXEL_BITS    = 32;
    localparam int INDEX_BITS    = 22;
    localparam int ADDR_BITS     = 5;

    localparam logic [SURF_W_BITS-1:0]   SURF_CODE_MAX   = 12'hFFF;
    localparam logic [SPRITE_W_BITS-1:0] SPRITE_SIDE_MAX = 11'd1024;

    typedef enum logic [2:0] {
        REG_SURF_W    = 3'd0,
        REG_SURF_H    = 3'd1,
        REG_PLACE_X   = 3'd2,
        REG_PLACE_Y   = 3'd3,
        REG_SPRITE_W  = 3'd4,
        REG_SPRITE_H  = 3'd5,
        REG_COLOR_KEY = 3'd6
    } t_reg_idx;

    // Effective configuration, already saturated to the legal ranges.
    typedef struct packed {
        logic [SURF_W_BITS-1:0]   surf_w;
        logic [SURF_W_BITS-1:0]   surf_h;
        logic [SURF_W_BITS-1:0]   place_x;
        logic [SURF_W_BITS-1:0]   place_y;
        logic [SPRITE_W_BITS-1:0] sprite_w;
        logic [SPRITE_W_BITS-1:0] sprite_h;
        logic [PIXEL_BITS-1:0]    color_key;
    } t_cfg;

    // One pixel with its mirrored destination position (two's complement).
    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel;
        logic [COORD_BITS-1:0] dx;
        logic [COORD_BITS-1:0] dy;
    } t_coord_item;

endpackage

/* design/mckb_cfg_regs.sv */
// ----------------------------------------------------------------------------
// mckb_cfg_regs
// APB register file holding the blit setup, with saturated effective values.
// ----------------------------------------------------------------------------
module mckb_cfg_regs #(
    parameter int MAX_SURFACE_SIDE = 2048
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mckb_pkg::ADDR_BITS-1:0]   paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    output mckb_pkg::t_cfg                   o_cfg
);

    // A cap above the largest register code never clips anything.
    localparam logic [mckb_pkg::SURF_W_BITS-1:0] SIDE_CAP =
        (MAX_SURFACE_SIDE > 4095) ? mckb_pkg::SURF_CODE_MAX
                                  : mckb_pkg::SURF_W_BITS'(MAX_SURFACE_SIDE);

    logic [mckb_pkg::SURF_W_BITS-1:0]   r_surf_w;
    logic [mckb_pkg::SURF_W_BITS-1:0]   r_surf_h;
    logic [mckb_pkg::SURF_W_BITS-1:0]   r_place_x;
    logic [mckb_pkg::SURF_W_BITS-1:0]   r_place_y;
    logic [mckb_pkg::SPRITE_W_BITS-1:0] r_sprite_w;
    logic [mckb_pkg::SPRITE_W_BITS-1:0] r_sprite_h;
    logic [mckb_pkg::PIXEL_BITS-1:0]    r_color_key;

    mckb_pkg::t_reg_idx reg_idx;
    logic               wr_en;

    assign pready  = 1'b1;
    assign reg_idx = mckb_pkg::t_reg_idx'(paddr[4:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_surf_w    <= 12'd320;
            r_surf_h    <= 12'd240;
            r_place_x   <= '0;
            r_place_y   <= '0;
            r_sprite_w  <= 11'd32;
            r_sprite_h  <= 11'd32;
            r_color_key <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                mckb_pkg::REG_SURF_W:    r_surf_w    <= pwdata[11:0];
                mckb_pkg::REG_SURF_H:    r_surf_h    <= pwdata[11:0];
                mckb_pkg::REG_PLACE_X:   r_place_x   <= pwdata[11:0];
                mckb_pkg::REG_PLACE_Y:   r_place_y   <= pwdata[11:0];
                mckb_pkg::REG_SPRITE_W:  r_sprite_w  <= pwdata[10:0];
                mckb_pkg::REG_SPRITE_H:  r_sprite_h  <= pwdata[10:0];
                mckb_pkg::REG_COLOR_KEY: r_color_key <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            mckb_pkg::REG_SURF_W:    prdata = {20'd0, r_surf_w};
            mckb_pkg::REG_SURF_H:    prdata = {20'd0, r_surf_h};
            mckb_pkg::REG_PLACE_X:   prdata = {20'd0, r_place_x};
            mckb_pkg::REG_PLACE_Y:   prdata = {20'd0, r_place_y};
            mckb_pkg::REG_SPRITE_W:  prdata = {21'd0, r_sprite_w};
            mckb_pkg::REG_SPRITE_H:  prdata = {21'd0, r_sprite_h};
            mckb_pkg::REG_COLOR_KEY: prdata = r_color_key;
            default:                 prdata = '0;
        endcase
    end

    // Saturation: surface sides to the cap, sprite sides to 1..1024.
    always_comb begin
        o_cfg.surf_w    = (r_surf_w > SIDE_CAP) ? SIDE_CAP : r_surf_w;
        o_cfg.surf_h    = (r_surf_h > SIDE_CAP) ? SIDE_CAP : r_surf_h;
        o_cfg.place_x   = r_place_x;
        o_cfg.place_y   = r_place_y;
        o_cfg.color_key = r_color_key;
        if (r_sprite_w == '0) begin
            o_cfg.sprite_w = 11'd1;
        end else if (r_sprite_w > mckb_pkg::SPRITE_SIDE_MAX) begin
            o_cfg.sprite_w = mckb_pkg::SPRITE_SIDE_MAX;
        end else begin
            o_cfg.sprite_w = r_sprite_w;
        end
        if (r_sprite_h == '0) begin
            o_cfg.sprite_h = 11'd1;
        end else if (r_sprite_h > mckb_pkg::SPRITE_SIDE_MAX) begin
            o_cfg.sprite_h = mckb_pkg::SPRITE_SIDE_MAX;
        end else begin
            o_cfg.sprite_h = r_sprite_h;
        end
    end

endmodule

/* design/mckb_coord.sv */
// ----------------------------------------------------------------------------
// mckb_coord
// Input register: column/row counters and the mirrored destination position.
// ----------------------------------------------------------------------------
module mckb_coord (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  mckb_pkg::t_cfg                     i_cfg,
    input  logic                               i_valid,
    input  logic [mckb_pkg::PIXEL_BITS-1:0]    i_pixel,
    output logic                               o_ready,
    input  logic                               i_next_ready,
    output logic                               o_valid,
    output mckb_pkg::t_coord_item              o_item
);

    logic [mckb_pkg::COUNT_BITS-1:0] r_col;
    logic [mckb_pkg::COUNT_BITS-1:0] r_row;
    logic                            r_valid;
    mckb_pkg::t_coord_item           r_item;

    logic [mckb_pkg::COUNT_BITS-1:0] n_col;
    logic [mckb_pkg::COUNT_BITS-1:0] n_row;
    logic [mckb_pkg::COUNT_BITS:0]   col_inc;
    logic [mckb_pkg::COUNT_BITS:0]   row_inc;
    logic [mckb_pkg::COORD_BITS-1:0] dx;
    logic [mckb_pkg::COORD_BITS-1:0] dy;
    logic                            accept;

    assign o_ready = !r_valid || i_next_ready;
    assign accept  = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        col_inc = {1'b0, r_col} + 11'd1;
        row_inc = {1'b0, r_row} + 11'd1;
        // A counter at or past the sprite size wraps, also after a resize.
        if (col_inc >= i_cfg.sprite_w) begin
            n_col = '0;
            n_row = (row_inc >= i_cfg.sprite_h) ? '0 : row_inc[9:0];
        end else begin
            n_col = col_inc[9:0];
            n_row = r_row;
        end
    end

    // Mirrored column: place_x + width - 1 - column; row: place_y + row.
    assign dx = {i_cfg.place_x[11], i_cfg.place_x} + {2'b00, i_cfg.sprite_w}
              - 13'd1 - {3'b000, r_col};
    assign dy = {i_cfg.place_y[11], i_cfg.place_y} + {3'b000, r_row};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.pixel <= i_pixel;
            r_item.dx    <= dx;
            r_item.dy    <= dy;
        end
    end

endmodule

/* design/mckb_clip_out.sv */
// ----------------------------------------------------------------------------
// mckb_clip_out
// Color-key and surface clip test, linear index, and the result register.
// ----------------------------------------------------------------------------
module mckb_clip_out (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  mckb_pkg::t_cfg                     i_cfg,
    input  logic                               i_valid,
    input  mckb_pkg::t_coord_item              i_item,
    output logic                               o_ready,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [mckb_pkg::INDEX_BITS-1:0]    o_index,
    output logic [mckb_pkg::PIXEL_BITS-1:0]    o_pixel
);

    logic                              r_valid;
    logic [mckb_pkg::INDEX_BITS-1:0]   r_index;
    logic [mckb_pkg::PIXEL_BITS-1:0]   r_pixel;

    logic                              in_surf;
    logic                              keep;
    logic [2*mckb_pkg::SURF_W_BITS-1:0] row_base;
    logic [mckb_pkg::INDEX_BITS-1:0]   index;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_index = r_index;
    assign o_pixel = r_pixel;

    // A non-negative coordinate always fits in its low 12 bits.
    assign in_surf = !i_item.dx[12] && !i_item.dy[12]
                  && (i_item.dx[11:0] < i_cfg.surf_w)
                  && (i_item.dy[11:0] < i_cfg.surf_h);
    assign keep    = in_surf && (i_item.pixel != i_cfg.color_key);

    assign row_base = i_item.dy[11:0] * i_cfg.surf_w;
    assign index    = row_base[mckb_pkg::INDEX_BITS-1:0]
                    + {10'd0, i_item.dx[11:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid && keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid && keep) begin
            r_index <= index;
            r_pixel <= i_item.pixel;
        end
    end

endmodule

/* design/mirrored_color_key_blitter.sv */
// ----------------------------------------------------------------------------
// mirrored_color_key_blitter
// Color-keyed sprite blit with horizontal mirroring and surface clipping.
// ----------------------------------------------------------------------------
// A kept pixel passes the input register, then the result register, and is
// offered on m_tvalid from there until m_tready takes it.
// Throughput: one pixel per cycle unless m_tready stalls the registers.
// Keyed or clipped pixels are consumed and produce no output transfer.
// Reset: synchronous, active low; counters go to zero and registers to
// their defaults at once, with no clearing pass.
module mirrored_color_key_blitter #(
    parameter int MAX_SURFACE_SIDE = 2048
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,   // [31:0] source_pixel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [55:0]                     m_tdata,   // [21:0] write_index,
                                                       // [53:22] write_pixel
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mckb_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    mckb_pkg::t_cfg                       cfg;
    mckb_pkg::t_coord_item                s1_item;
    logic                                 s1_valid;
    logic                                 st2_ready;
    logic [mckb_pkg::INDEX_BITS-1:0]      out_index;
    logic [mckb_pkg::PIXEL_BITS-1:0]      out_pixel;

    mckb_cfg_regs #(
        .MAX_SURFACE_SIDE (MAX_SURFACE_SIDE)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mckb_coord u_coord (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_valid      (s_tvalid),
        .i_pixel      (s_tdata),
        .o_ready      (s_tready),
        .i_next_ready (st2_ready),
        .o_valid      (s1_valid),
        .o_item       (s1_item)
    );

    mckb_clip_out u_clip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (s1_valid),
        .i_item  (s1_item),
        .o_ready (st2_ready),
        .o_valid (m_tvalid),
        .i_ready (m_tready),
        .o_index (out_index),
        .o_pixel (out_pixel)
    );

    assign m_tdata = {2'b00, out_pixel, out_index};

`ifndef SYNTHESIS
    // An accepted pixel always occupies the input register next cycle.
    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> s1_valid)
        else $error("accepted pixel did not reach the input register");

    // With both stages full and the output stalled, no new pixel may enter.
    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_valid && m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while the pipeline is full and stalled");

    // Reset empties both stages.
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (!m_tvalid && !s1_valid))
        else $error("pipeline not empty after reset");
`endif

endmodule
